/* design/assert_macros.svh */
// Assertion helpers used by line_aware_char_fifo.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/lacf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lacf_pkg: shared constants and types
// Sizes of the cell chain and occupancy counters, operation codes, characters.
// ----------------------------------------------------------------------------
package lacf_pkg;

    // Depth figure; the chain has DEPTH-1 cells, so DEPTH-1 bytes are held
    localparam int DEPTH     = 64;
    localparam int NUM_CELLS = DEPTH - 1;
    localparam int CNT_W     = (DEPTH > 2) ? $clog2(DEPTH) : 1;

    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [7:0]       char_t;

    localparam cnt_t CNT_FULL = cnt_t'(NUM_CELLS);
    localparam cnt_t CNT_ZERO = '0;
    localparam cnt_t CNT_ONE  = cnt_t'(1);

    // Operation codes
    localparam logic OP_PUT = 1'b0;
    localparam logic OP_GET = 1'b1;

    // Characters of interest
    localparam char_t CHAR_NEWLINE = 8'h0A;
    localparam char_t CHAR_NUL     = 8'h00;

endpackage

/* design/line_aware_char_fifo.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// line_aware_char_fifo: byte FIFO with complete-line detection
// Chain of byte cells with the oldest byte at the front, plus fill and
// newline counters and a registered result stage.
// ----------------------------------------------------------------------------
// Each input beat is a put or a get and yields exactly one result beat. The
// block holds DEPTH-1 bytes in a row of cells: a put loads the first free
// cell, a get takes the front cell while every cell takes its neighbor's byte.
// A put to a full FIFO is dropped and a get from an empty one returns 0, both
// with done_res low. line_ready reports that at least one newline byte is
// held, from a running newline count. One beat is taken per clock cycle; the
// result register frees as its beat is taken, so the rate is set only by the
// output side's ready. Reset clears control state only, no clearing pass.
// ----------------------------------------------------------------------------
module line_aware_char_fifo (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic [7:0]  s_char_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_char_out,
    output logic        m_done_res,
    output logic        m_line_ready,
    output logic        m_is_empty
);

    lacf_pkg::char_t cell_data [lacf_pkg::NUM_CELLS];

    lacf_pkg::cnt_t  count_reg,   count_next;
    lacf_pkg::cnt_t  nl_cnt_reg,  nl_cnt_next;
    logic            m_valid_reg, m_valid_next;
    lacf_pkg::char_t m_char_reg,  m_char_next;
    logic            m_done_reg,  m_done_next;
    logic            m_line_reg,  m_line_next;
    logic            m_empty_reg, m_empty_next;

    logic            accept;
    logic            is_full;
    logic            is_empt;
    logic            put_ok;
    logic            get_ok;
    lacf_pkg::char_t head_char;

    // Handshake and operation decode
    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign is_full   = (count_reg == lacf_pkg::CNT_FULL);
    assign is_empt   = (count_reg == lacf_pkg::CNT_ZERO);
    assign put_ok    = accept && (s_operation == lacf_pkg::OP_PUT) && !is_full;
    assign get_ok    = accept && (s_operation == lacf_pkg::OP_GET) && !is_empt;
    assign head_char = cell_data[0];

    // Cell chain: cell i loads when it is the first free slot
    for (genvar i = 0; i < lacf_pkg::NUM_CELLS; i++) begin : g_cell
        localparam lacf_pkg::cnt_t CellIdx = lacf_pkg::cnt_t'(i);
        lacf_pkg::char_t from_above;

        if (i == lacf_pkg::NUM_CELLS - 1) begin : g_last
            assign from_above = lacf_pkg::CHAR_NUL;
        end else begin : g_mid
            assign from_above = cell_data[i+1];
        end

        lacf_cell u_cell (
            .aclk      (aclk),
            .load_en   (put_ok && (count_reg == CellIdx)),
            .shift_en  (get_ok),
            .load_data (s_char_in),
            .shift_in  (from_above),
            .data_out  (cell_data[i])
        );
    end

    // Counters and result stage next values
    always_comb begin
        count_next   = count_reg;
        nl_cnt_next  = nl_cnt_reg;
        m_valid_next = m_valid_reg;
        m_char_next  = m_char_reg;
        m_done_next  = m_done_reg;
        m_line_next  = m_line_reg;
        m_empty_next = m_empty_reg;

        if (put_ok) begin
            count_next = count_reg + lacf_pkg::CNT_ONE;
            if (s_char_in == lacf_pkg::CHAR_NEWLINE) begin
                nl_cnt_next = nl_cnt_reg + lacf_pkg::CNT_ONE;
            end
        end else if (get_ok) begin
            count_next = count_reg - lacf_pkg::CNT_ONE;
            if ((head_char == lacf_pkg::CHAR_NEWLINE) &&
                (nl_cnt_reg != lacf_pkg::CNT_ZERO)) begin
                nl_cnt_next = nl_cnt_reg - lacf_pkg::CNT_ONE;
            end
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (accept) begin
            m_valid_next = 1'b1;
            m_char_next  = get_ok ? head_char : lacf_pkg::CHAR_NUL;
            m_done_next  = put_ok || get_ok;
            m_line_next  = (nl_cnt_next != lacf_pkg::CNT_ZERO);
            m_empty_next = (count_next == lacf_pkg::CNT_ZERO);
        end
    end

    // Control state with reset; result payload without
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= lacf_pkg::CNT_ZERO;
            nl_cnt_reg  <= lacf_pkg::CNT_ZERO;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            nl_cnt_reg  <= nl_cnt_next;
            m_valid_reg <= m_valid_next;
        end
        m_char_reg  <= m_char_next;
        m_done_reg  <= m_done_next;
        m_line_reg  <= m_line_next;
        m_empty_reg <= m_empty_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_char_out   = m_char_reg;
    assign m_done_res   = m_done_reg;
    assign m_line_ready = m_line_reg;
    assign m_is_empty   = m_empty_reg;

    // Checks
    `ASSERT_ALWAYS(a_nl_le_count, aclk, aresetn,
        nl_cnt_reg <= count_reg, "newline count exceeds fill")
    `ASSERT_ALWAYS(a_count_max, aclk, aresetn,
        count_reg <= lacf_pkg::CNT_FULL, "fill count overflow")
    `ASSERT_ALWAYS(a_empty_flag, aclk, aresetn,
        !m_valid_reg || (m_empty_reg == (count_reg == lacf_pkg::CNT_ZERO)),
        "empty flag out of step with fill")
    `ASSERT_ALWAYS(a_line_flag, aclk, aresetn,
        !m_valid_reg || (m_line_reg == (nl_cnt_reg != lacf_pkg::CNT_ZERO)),
        "line flag out of step with newline count")
    `ASSERT_NEXT(a_drop_keeps, aclk, aresetn, accept && !put_ok && !get_ok,
        $stable(count_reg) && $stable(nl_cnt_reg), "failed beat changed state")

endmodule

/* design/lacf_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lacf_cell: one byte slot of the FIFO chain
// Loads the incoming byte when it is the first free slot, or takes its upper
// neighbor's byte when the head byte leaves the chain.
// ----------------------------------------------------------------------------
module lacf_cell (
    input  logic             aclk,
    input  logic             load_en,
    input  logic             shift_en,
    input  lacf_pkg::char_t  load_data,
    input  lacf_pkg::char_t  shift_in,
    output lacf_pkg::char_t  data_out
);

    lacf_pkg::char_t data_reg;
    lacf_pkg::char_t data_next;

    // next byte: neighbor on a shift, new byte on a load, else hold
    always_comb begin
        data_next = data_reg;
        if (shift_en) begin
            data_next = shift_in;
        end else if (load_en) begin
            data_next = load_data;
        end
    end

    // payload only, no reset
    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_out = data_reg;

endmodule
